[design/fcg_pkg.sv]
// ----------------------------------------------------------------------------
// fcg_pkg - shared types and constants for the Fletcher check-byte generator
// Record passed from the front to the back, queue status, arithmetic consts.
// ----------------------------------------------------------------------------
package fcg_pkg;

    // modulus of both running sums
    localparam logic [9:0]  MOD_VAL   = 10'd255;
    // base for the second check byte
    localparam logic [9:0]  Y_BASE    = 10'd510;
    // reset value of the check position register
    localparam logic [15:0] POS_RESET = 16'd15;

    // one finished message, as the back part needs it
    typedef struct packed {
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic [7:0] cnt_mod;   // byte count modulo 255
    } t_msg_rec;

    // status of a small queue
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/fcg_fifo.sv]
// ----------------------------------------------------------------------------
// fcg_fifo - small register queue
// First-word-fall-through queue, head word visible while not empty.
// ----------------------------------------------------------------------------
module fcg_fifo
    import fcg_pkg::*;
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output t_q_status        o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_cnt,    n_cnt;
    logic             w_wr, w_rd;

    // handshake qualified by status
    assign w_wr = i_wr_en && !o_status.full;
    assign w_rd = i_rd_en && !o_status.empty;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_rd_data      = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

[design/fcg_front.sv]
// ----------------------------------------------------------------------------
// fcg_front - byte intake and running sums
// Keeps sum_a, sum_b and the saturating byte count; on the last byte it
// queues the message record and clears for the next message.
// ----------------------------------------------------------------------------
module fcg_front
    import fcg_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic [7:0] i_data_byte,
    input  logic      i_last,
    output logic      o_rec_push,
    output t_msg_rec  o_rec
);

    logic [7:0]             r_sum_a,   n_sum_a;
    logic [7:0]             r_sum_b,   n_sum_b;
    logic [COUNT_WIDTH-1:0] r_count,   n_count;
    logic [7:0]             r_cnt_mod, n_cnt_mod;
    logic [9:0]             w_add_a, w_add_b;
    logic                   w_not_sat;

    // updated sums, one conditional subtract each
    always_comb begin
        w_add_a = {2'b00, r_sum_a} + {2'b00, i_data_byte};
        n_sum_a = (w_add_a >= MOD_VAL) ? 8'(w_add_a - MOD_VAL) : w_add_a[7:0];
        w_add_b = {2'b00, r_sum_b} + {2'b00, n_sum_a};
        n_sum_b = (w_add_b >= MOD_VAL) ? 8'(w_add_b - MOD_VAL) : w_add_b[7:0];
    end

    // count saturates; its residue stops with it
    always_comb begin
        w_not_sat = (r_count != '1);
        n_count   = r_count;
        n_cnt_mod = r_cnt_mod;
        if (w_not_sat) begin
            n_count   = r_count + 1'b1;
            n_cnt_mod = ({2'b00, r_cnt_mod} == MOD_VAL - 10'd1) ? 8'd0
                                                                 : r_cnt_mod + 8'd1;
        end
    end

    // record for the back part
    assign o_rec_push    = i_accept && i_last;
    assign o_rec.sum_a   = n_sum_a;
    assign o_rec.sum_b   = n_sum_b;
    assign o_rec.cnt_mod = n_cnt_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_count   <= '0;
            r_cnt_mod <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_sum_a   <= '0;
                r_sum_b   <= '0;
                r_count   <= '0;
                r_cnt_mod <= '0;
            end else begin
                r_sum_a   <= n_sum_a;
                r_sum_b   <= n_sum_b;
                r_count   <= n_count;
                r_cnt_mod <= n_cnt_mod;
            end
        end
    end

endmodule

[design/fcg_back.sv]
// ----------------------------------------------------------------------------
// fcg_back - check byte computation
// Stage 1 forms the position offset and multiplies; stage 2 reduces and
// derives X and Y, writing the result queue.
// ----------------------------------------------------------------------------
module fcg_back
    import fcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  t_msg_rec    i_rec,
    input  t_q_status   i_rec_status,
    output logic        o_rec_pop,
    input  t_q_status   i_out_status,
    output logic        o_out_push,
    output logic [15:0] o_out_data
);

    logic [15:0] r_pos;
    logic        r_s1_valid;
    logic [15:0] r_prod;
    logic [7:0]  r_sa, r_sb;
    logic        w_s1_ready;
    logic [9:0]  w_pfold, w_pr1, w_pm, w_d;
    logic [15:0] w_prod;
    logic [9:0]  w_fold, w_pmod, w_xraw, w_x, w_y0, w_y;

    // check position register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_RESET;
        end else if (i_cfg_wr_en) begin
            r_pos <= i_cfg_wr_data;
        end
    end

    // position modulo 255 (256 = 1 mod 255) and offset d
    always_comb begin
        w_pfold = {2'b00, r_pos[15:8]} + {2'b00, r_pos[7:0]};
        w_pr1   = (w_pfold >= MOD_VAL) ? w_pfold - MOD_VAL : w_pfold;
        w_pm    = (w_pr1 == MOD_VAL) ? 10'd0 : w_pr1;
        w_d     = ({2'b00, i_rec.cnt_mod} >= w_pm)
                ? {2'b00, i_rec.cnt_mod} - w_pm
                : {2'b00, i_rec.cnt_mod} + MOD_VAL - w_pm;
        w_prod  = {8'd0, w_d[7:0]} * {8'd0, i_rec.sum_a};
    end

    // stage 1 advance
    assign w_s1_ready = !r_s1_valid || !i_out_status.full;
    assign o_rec_pop  = !i_rec_status.empty && w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= !i_rec_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_prod <= w_prod;
            r_sa   <= i_rec.sum_a;
            r_sb   <= i_rec.sum_b;
        end
    end

    // stage 2: X = (d*a - b) mod 255 in 1..255, Y = 510 - a - X reduced once
    always_comb begin
        w_fold = {2'b00, r_prod[15:8]} + {2'b00, r_prod[7:0]};
        w_pmod = (w_fold >= MOD_VAL) ? w_fold - MOD_VAL : w_fold;
        w_xraw = (w_pmod >= {2'b00, r_sb}) ? w_pmod - {2'b00, r_sb}
                                           : w_pmod + MOD_VAL - {2'b00, r_sb};
        w_x    = (w_xraw == 10'd0) ? MOD_VAL : w_xraw;
        w_y0   = Y_BASE - {2'b00, r_sa} - w_x;
        w_y    = (w_y0 > MOD_VAL) ? w_y0 - MOD_VAL : w_y0;
    end

    assign o_out_push = r_s1_valid && !i_out_status.full;
    assign o_out_data = {w_x[7:0], w_y[7:0]};

endmodule

[design/fletcher_checkbyte_generator.sv]
// ----------------------------------------------------------------------------
// fletcher_checkbyte_generator - Fletcher (ISO 8473) check byte generator
// Takes one byte per cycle unless full; after the last byte it delivers X/Y.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless full (combinational mod-255 sum update).
// The check word reaches the result side through the record queue, then the
// multiply stage, then the result queue; a full result queue stalls it.
// Reset (synchronous, active low): sums and count cleared, queues emptied,
// check position set to 15.
// ----------------------------------------------------------------------------
module fletcher_checkbyte_generator
    import fcg_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_checksum
);

    localparam int REC_W = $bits(t_msg_rec);

    t_msg_rec    w_rec_in, w_rec_out;
    logic [REC_W-1:0] w_rec_rd;
    logic        w_rec_push, w_rec_pop, w_accept;
    t_q_status   w_rec_status, w_out_status;
    logic        w_out_push;
    logic [15:0] w_out_data;

    assign w_accept  = push && !full;
    assign full      = w_rec_status.full;
    assign empty     = w_out_status.empty;
    assign w_rec_out = t_msg_rec'(w_rec_rd);

    // front: intake and running sums
    fcg_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_rec_push  (w_rec_push),
        .o_rec       (w_rec_in)
    );

    // record queue between front and back
    fcg_fifo #(
        .WIDTH (REC_W),
        .DEPTH (2)
    ) u_rec_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_rec_push),
        .i_wr_data (w_rec_in),
        .i_rd_en   (w_rec_pop),
        .o_rd_data (w_rec_rd),
        .o_status  (w_rec_status)
    );

    // back: check byte arithmetic
    fcg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rec         (w_rec_out),
        .i_rec_status  (w_rec_status),
        .o_rec_pop     (w_rec_pop),
        .i_out_status  (w_out_status),
        .o_out_push    (w_out_push),
        .o_out_data    (w_out_data)
    );

    // result queue
    fcg_fifo #(
        .WIDTH (16),
        .DEPTH (2)
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_out_push),
        .i_wr_data (w_out_data),
        .i_rd_en   (pop),
        .o_rd_data (o_checksum),
        .o_status  (w_out_status)
    );

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for the Fletcher check-byte generator
// Streams messages through the block and predicts each X/Y check word from
// the bytes it accepts. The position register is changed between phases.
// Both sides idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb
    import fcg_pkg::*;
();

    localparam int          COUNT_W      = 16;
    localparam int unsigned MODULUS      = MOD_VAL;
    localparam int unsigned Y_OFFSET     = Y_BASE;
    localparam int          RESET_CYCLES = 11;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SEG_BYTES    = 145;
    localparam int          LIMIT_CYCLES = 40000;

    // Predicts check words from accepted bytes and checks the words popped
    class checkword_board;
        bit [15:0]        position;
        bit [7:0]         sum_a;
        bit [7:0]         sum_b;
        bit [COUNT_W-1:0] byte_count;
        bit [15:0]        expected_words[$];
        int               errors;
        int               n_bytes;
        int               n_msgs;
        int               n_positions;

        function new();
            position    = POS_RESET;
            sum_a       = '0;
            sum_b       = '0;
            byte_count  = '0;
            errors      = 0;
            n_bytes     = 0;
            n_msgs      = 0;
            n_positions = 1;
        endfunction

        function void set_position(bit [15:0] pos);
            position = pos;
            n_positions++;
        endfunction

        // running sums per byte; on the last byte work out X and Y and clear
        function void note_byte(bit [7:0] data, bit last);
            int unsigned cnt_m;
            int unsigned pos_m;
            int unsigned d;
            int unsigned x;
            int unsigned y;
            n_bytes++;
            if (byte_count != '1)
                byte_count++;
            sum_a = 8'((int'(sum_a) + int'(data)) % MODULUS);
            sum_b = 8'((int'(sum_b) + int'(sum_a)) % MODULUS);
            if (!last)
                return;
            cnt_m = int'(byte_count) % MODULUS;
            pos_m = int'(position) % MODULUS;
            d     = (cnt_m + MODULUS - pos_m) % MODULUS;
            x     = ((d * sum_a) % MODULUS + MODULUS - sum_b) % MODULUS;
            if (x == 0)
                x = MODULUS;
            y = Y_OFFSET - sum_a - x;
            if (y > MODULUS)
                y -= MODULUS;
            expected_words.push_back({x[7:0], y[7:0]});
            n_msgs++;
            sum_a      = '0;
            sum_b      = '0;
            byte_count = '0;
        endfunction

        function void check_word(bit [15:0] got);
            bit [15:0] want;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: check word %h popped with none expected", $time, got);
                return;
            end
            want = expected_words.pop_front();
            if (want !== got) begin
                errors++;
                $display("%0t: check word mismatch, expected %h, actual %h",
                         $time, want, got);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        empty;
    logic        pop;
    logic [15:0] o_checksum;

    checkword_board sb;
    int unsigned    tx_idle_pct = 28;
    int unsigned    rx_idle_pct = 45;
    int             hold_left   = 0;
    bit             rst_done    = 1'b0;
    int             cycles      = 0;

    fletcher_checkbyte_generator #(.COUNT_WIDTH(COUNT_W)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .empty         (empty),
        .pop           (pop),
        .o_checksum    (o_checksum)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: check each popped word, random stalls or a counted hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                sb.check_word(o_checksum);
            if (!rst_done) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one byte, wait for it to be taken, then maybe idle a while
    task automatic send_byte(input bit [7:0] data, input bit last);
        push        <= 1'b1;
        i_data_byte <= data;
        i_last      <= last;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sb.note_byte(data, last);
        while ($urandom_range(99) < tx_idle_pct) begin
            push        <= 1'b0;
            i_data_byte <= 8'($urandom);
            i_last      <= 1'($urandom);
            @(posedge i_clk);
        end
    endtask

    // biased towards the values that reduce to zero modulo 255
    function automatic bit [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 1; i <= len; i++)
            send_byte(pick_byte(), i == len);
    endtask

    // random messages, mostly short, now and then longer than position 255
    task automatic run_segment(input int unsigned target);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(24) == 0)
                len = $urandom_range(17, 280);
            else
                len = $urandom_range(1, 16);
            send_message(len);
            sent += len;
        end
    endtask

    // idle: every word back, then a drain wait for anything still in flight
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_position(input bit [15:0] pos);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= pos;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_position(pos);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        push          = 1'b0;
        i_data_byte   = '0;
        i_last        = 1'b0;
        pop           = 1'b0;
        sb            = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // directed, at the reset position: single-byte messages, all-zero
        // and all-FF content (sums stay zero, X maps to 255), and a message
        // with its check bytes zeroed at positions 15 and 16
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b1);
        send_message_ff: for (int i = 1; i <= 3; i++)
            send_byte(8'hFF, i == 3);
        for (int i = 1; i <= 16; i++) begin
            if (i == 15 || i == 16)
                send_byte(8'h00, i == 16);
            else
                send_byte((i % 2) ? 8'hA5 : 8'h5A, 1'b0);
        end
        wait_drained();

        // sender idles 28 %, receiver 45 %
        write_position(16'd1);
        run_segment(SEG_BYTES);
        wait_drained();
        write_position(16'd255);
        run_segment(SEG_BYTES);
        wait_drained();

        // the other way round, position beyond any message, then 256
        tx_idle_pct = 45;
        rx_idle_pct = 28;
        write_position(16'hFFFF);
        run_segment(SEG_BYTES);
        wait_drained();
        write_position(16'd256);
        run_segment(SEG_BYTES);
        wait_drained();

        // no idling; long receiver hold-off while bytes keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_position(16'($urandom_range(2, 65534)));
        hold_left = HOLD_CYCLES;
        run_segment(SEG_BYTES);
        wait_drained();
        write_position(16'($urandom_range(1, 20)));
        run_segment(SEG_BYTES);
        wait_drained();

        $display("Covered %0d bytes in %0d messages over %0d check positions,",
                 sb.n_bytes, sb.n_msgs, sb.n_positions);
        $display("with idle mixes on both sides and a full-queue hold-off.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
design/fcg_pkg.sv
design/fcg_fifo.sv
design/fcg_front.sv
design/fcg_back.sv
design/fletcher_checkbyte_generator.sv
verif/tb.sv
